/* sv/ook_enc_pkg.sv */
// ----------------------------------------------------------------------------
// ook_enc_pkg
// Shared types and constants for the OOK key-fob pulse encoder.
// ----------------------------------------------------------------------------
package ook_enc_pkg;

  // Width of a pulse duration on the output stream
  localparam int unsigned DurW = 21;

  // Widths of the input fields
  localparam int unsigned KeyW   = 8;
  localparam int unsigned NBitsW = 4;

  // Most bits a byte can carry
  localparam logic [NBitsW-1:0] MaxBits = NBitsW'(8);

  // Protocol mode codes
  localparam logic [1:0] MODE_BIPHASE_LONG  = 2'd0;
  localparam logic [1:0] MODE_PWM           = 2'd1;
  localparam logic [1:0] MODE_BIPHASE_SHORT = 2'd2;
  localparam logic [1:0] MODE_UNUSED        = 2'd3;

  // Register indexes (byte address is 4 * index)
  localparam logic REG_PROTOCOL_MODE = 1'b0;
  localparam logic REG_TIME_ELEMENT  = 1'b1;

  // Pulse sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_HI,
    ST_PRE_LO,
    ST_BIT_A,
    ST_BIT_B,
    ST_TRAIL
  } seq_state_e;

  // Multiples of the time element the duration unit can form
  typedef enum logic [1:0] {
    MUL_1,
    MUL_3,
    MUL_30,
    MUL_31
  } te_mul_e;

endpackage

/* sv/ook_remote_pulse_encoder.sv */
// ----------------------------------------------------------------------------
// ook_remote_pulse_encoder
// Turns key bytes into on-off-keyed pulses (level, duration) in pulse-width
// or biphase coding, with a preamble (pulse-width mode only) and trailer, under an APB register port.
// ----------------------------------------------------------------------------
// Start: a taken byte request is registered into the sequencer state; the first pulse is
//   formed from that state and registered in the output register once the slot is free.
// Throughput: one pulse per cycle while the output is not stalled, from a single
//   shift/add duration unit; the input is ready again only once all pulses of a byte (0..19) are loaded.
// Reset: rst_ni asynchronous, active low; mode 0, time element 0, no frame open.
module ook_remote_pulse_encoder
  import ook_enc_pkg::*;
#(
  parameter int unsigned TE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] key_byte, [11:8] valid_bits, [15:12] zero
  input  logic        s_axis_tlast,   // last_byte

  // Output pulses
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] pulse_level, [21:1] pulse_duration, [23:22] zero
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // frame_end
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]         mode_q;
  logic [TE_BITS-1:0] te_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BIPHASE_LONG;
      te_q   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TIME_ELEMENT) begin
        te_q <= pwdata[TE_BITS-1:0];
      end else begin
        mode_q <= pwdata[1:0];
      end
    end
  end

  // Read back
  logic [TE_BITS+31:0] te_rd;
  assign te_rd = {32'd0, te_q};

  always_comb begin
    if (paddr[2] == REG_TIME_ELEMENT) begin
      prdata = te_rd[31:0];
    end else begin
      prdata = {30'd0, mode_q};
    end
  end

  // --------------------------------------------------------------------------
  // Shared duration unit: te times 1, 3, 30 or 31 by one shift-add/subtract
  // --------------------------------------------------------------------------
  logic [TE_BITS+DurW-1:0] te_wide;
  logic [DurW-1:0]         te_ext;
  te_mul_e                 mul_sel;
  logic [DurW-1:0]         op_a, op_b;
  logic                    op_sub;
  logic [DurW-1:0]         dur;

  assign te_wide = {{DurW{1'b0}}, te_q};
  assign te_ext  = te_wide[DurW-1:0];

  always_comb begin
    op_a   = te_ext;
    op_b   = '0;
    op_sub = 1'b0;
    case (mul_sel)
      MUL_1: begin
        op_a = te_ext;
        op_b = '0;
      end
      MUL_3: begin
        op_a = te_ext << 1;
        op_b = te_ext;
      end
      MUL_30: begin
        op_a   = te_ext << 5;
        op_b   = te_ext << 1;
        op_sub = 1'b1;
      end
      MUL_31: begin
        op_a   = te_ext << 5;
        op_b   = te_ext;
        op_sub = 1'b1;
      end
      default: begin
        op_a = te_ext;
        op_b = '0;
      end
    endcase
  end

  assign dur = op_sub ? (op_a - op_b) : (op_a + op_b);

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  seq_state_e         state_q, state_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [NBitsW-1:0]  cnt_q, cnt_d;
  logic               last_q, last_d;
  logic               fip_q, fip_d;

  logic               out_valid_q, out_valid_d;
  logic               out_level_q, out_level_d;
  logic [DurW-1:0]    out_dur_q, out_dur_d;
  logic               out_last_q, out_last_d;
  logic               out_fend_q, out_fend_d;

  logic               in_req;
  logic               slot_free;
  logic               load;
  logic               active;
  logic [KeyW-1:0]    in_key;
  logic [NBitsW-1:0]  in_nbits;
  logic [NBitsW-1:0]  in_nbits_sat;
  logic               cur_bit;
  logic               pulse_level;
  logic               pulse_fend;
  seq_state_e         after_bits;
  seq_state_e         nxt;

  assign in_key       = s_axis_tdata[KeyW-1:0];
  assign in_nbits     = s_axis_tdata[KeyW+NBitsW-1:KeyW];
  assign in_nbits_sat = (in_nbits > MaxBits) ? MaxBits : in_nbits;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign active        = (te_q != '0) && (mode_q != MODE_UNUSED);
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign cur_bit       = key_q[KeyW-1];
  assign after_bits    = last_q ? ST_TRAIL : ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fip_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fip_q       <= fip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cnt_q       <= cnt_d;
    last_q      <= last_d;
    out_level_q <= out_level_d;
    out_dur_q   <= out_dur_d;
    out_last_q  <= out_last_d;
    out_fend_q  <= out_fend_d;
  end

  // Next state and pulse forming
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    fip_d       = fip_q;
    mul_sel     = MUL_1;
    pulse_level = 1'b0;
    pulse_fend  = 1'b0;
    nxt         = ST_IDLE;
    load        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_req && active) begin
          key_d  = in_key;
          cnt_d  = in_nbits_sat;
          last_d = s_axis_tlast;
          fip_d  = !s_axis_tlast;
          if (mode_q == MODE_PWM && !fip_q) begin
            state_d = ST_PRE_HI;
          end else if (in_nbits_sat != '0) begin
            state_d = ST_BIT_A;
          end else if (s_axis_tlast) begin
            state_d = ST_TRAIL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PRE_HI: begin
        pulse_level = 1'b1;
        mul_sel     = MUL_1;
        nxt         = ST_PRE_LO;
        load        = slot_free;
      end
      ST_PRE_LO: begin
        pulse_level = 1'b0;
        mul_sel     = MUL_31;
        nxt         = (cnt_q != '0) ? ST_BIT_A : after_bits;
        load        = slot_free;
      end
      ST_BIT_A: begin
        if (mode_q == MODE_PWM) begin
          pulse_level = 1'b1;
          mul_sel     = cur_bit ? MUL_3 : MUL_1;
        end else begin
          pulse_level = cur_bit;
          mul_sel     = MUL_1;
        end
        nxt  = ST_BIT_B;
        load = slot_free;
      end
      ST_BIT_B: begin
        if (mode_q == MODE_PWM) begin
          pulse_level = 1'b0;
          mul_sel     = cur_bit ? MUL_1 : MUL_3;
        end else begin
          pulse_level = !cur_bit;
          mul_sel     = MUL_1;
        end
        nxt  = (cnt_q > NBitsW'(1)) ? ST_BIT_A : after_bits;
        load = slot_free;
        if (slot_free) begin
          key_d = key_q << 1;
          cnt_d = cnt_q - NBitsW'(1);
        end
      end
      ST_TRAIL: begin
        pulse_level = 1'b0;
        pulse_fend  = 1'b1;
        mul_sel     = (mode_q == MODE_BIPHASE_LONG) ? MUL_30 : MUL_1;
        nxt         = ST_IDLE;
        load        = slot_free;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      state_d = nxt;
    end
  end

  // Output register
  always_comb begin
    out_level_d = out_level_q;
    out_dur_d   = out_dur_q;
    out_last_d  = out_last_q;
    out_fend_d  = out_fend_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_level_d = pulse_level;
      out_dur_d   = dur;
      out_last_d  = (nxt == ST_IDLE);
      out_fend_d  = pulse_fend;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_dur_q, out_level_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fend_q;

`ifndef SYNTHESIS
  // Trailer is always the final pulse of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end pulse without run_last");

  // Trailer is always carrier off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
    else $error("frame end pulse with carrier on");

  // Bit states only with bits left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIT_A || state_q == ST_BIT_B) |-> (cnt_q != '0))
    else $error("bit pulse with no bits left");

  // A finished run returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (nxt == ST_IDLE) |=> s_axis_tready)
    else $error("sequencer not idle after last pulse");
`endif

endmodule
